// ===== hdl/vit_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Viterbi decoder.
// Used by vit_tables, vit_trellis and hmm_viterbi_decoder; depends on nothing.
package vit_pkg;

   localparam int MAX_STATES  = 8;
   localparam int ST_W        = 3;
   localparam int MAX_SYMBOLS = 16;
   localparam int SYM_W       = 4;
   localparam int VAL_W       = 16;
   localparam int SCORE_W     = 32;
   localparam int TR_AW       = 2 * ST_W;
   localparam int EM_AW       = ST_W + SYM_W;

   localparam logic [1:0] KIND_TRANS = 2'd0;
   localparam logic [1:0] KIND_EMIS  = 2'd1;
   localparam logic [1:0] KIND_INIT  = 2'd2;
   localparam logic [1:0] KIND_OBS   = 2'd3;

   localparam logic CSR_NUM_STATES  = 1'b0;
   localparam logic CSR_NUM_SYMBOLS = 1'b1;

   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
   localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OBS_RUN,
      ST_OBS_DRAIN,
      ST_BEST_RUN,
      ST_BEST_DRAIN,
      ST_TRACE_RD,
      ST_TRACE_WR,
      ST_OUT_RUN,
      ST_OUT_DRAIN,
      ST_EMPTY
   } ctrl_state_type;

   typedef struct packed {
      logic                    en_trans;
      logic                    en_emis;
      logic                    en_init;
      logic [ST_W-1:0]         row;
      logic [SYM_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
   } tbl_load_type;

   typedef struct packed {
      logic [TR_AW-1:0] trans_addr;
      logic [EM_AW-1:0] emis_addr;
      logic [ST_W-1:0]  init_addr;
   } tbl_read_type;

   function automatic logic signed [SCORE_W-1:0] sat_add(
      input logic signed [SCORE_W-1:0] a,
      input logic signed [SCORE_W-1:0] b
   );
      logic signed [SCORE_W:0] s;
      s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
      if (s[SCORE_W] != s[SCORE_W-1]) begin
         sat_add = s[SCORE_W] ? SCORE_MIN : SCORE_MAX;
      end else begin
         sat_add = s[SCORE_W-1:0];
      end
   endfunction

   function automatic logic signed [SCORE_W-1:0] sext_val(input logic signed [VAL_W-1:0] v);
      sext_val = {{(SCORE_W-VAL_W){v[VAL_W-1]}}, v};
   endfunction

endpackage

// ===== hdl/vit_tables.sv =====
// Transition, emission and initial log-probability memories of the decoder.
// Depends on vit_pkg for the load and read structures.
module vit_tables (
   input  logic                               clock,
   input  vit_pkg::tbl_load_type              load,
   input  vit_pkg::tbl_read_type              rd,
   output logic signed [vit_pkg::VAL_W-1:0]   trans_rdata,
   output logic signed [vit_pkg::VAL_W-1:0]   emis_rdata,
   output logic signed [vit_pkg::VAL_W-1:0]   init_rdata
);
   import vit_pkg::*;

   logic signed [VAL_W-1:0] trans_mem [MAX_STATES*MAX_STATES];
   logic signed [VAL_W-1:0] emis_mem  [MAX_STATES*MAX_SYMBOLS];
   logic signed [VAL_W-1:0] init_mem  [MAX_STATES];

   always_ff @(posedge clock) begin
      if (load.en_trans) begin
         trans_mem[{load.row, load.col[ST_W-1:0]}] <= load.value;
      end
      if (load.en_emis) begin
         emis_mem[{load.row, load.col}] <= load.value;
      end
      if (load.en_init) begin
         init_mem[load.row] <= load.value;
      end
      trans_rdata <= trans_mem[rd.trans_addr];
      emis_rdata  <= emis_mem[rd.emis_addr];
      init_rdata  <= init_mem[rd.init_addr];
   end

endmodule

// ===== hdl/vit_trellis.sv =====
// Path score, back pointer and decoded path memories of the decoder.
// Depends on vit_pkg for widths; the sequence depth comes from MAX_LEN.
module vit_trellis #(
   parameter int MAX_LEN = 64
) (
   input  logic                                 clock,
   input  logic                                 sc_we,
   input  logic [vit_pkg::ST_W:0]               sc_waddr,
   input  logic signed [vit_pkg::SCORE_W-1:0]   sc_wdata,
   input  logic [vit_pkg::ST_W:0]               sc_raddr,
   output logic signed [vit_pkg::SCORE_W-1:0]   sc_rdata,
   input  logic                                 bp_we,
   input  logic [$clog2(MAX_LEN)+vit_pkg::ST_W-1:0] bp_waddr,
   input  logic [vit_pkg::ST_W-1:0]             bp_wdata,
   input  logic [$clog2(MAX_LEN)+vit_pkg::ST_W-1:0] bp_raddr,
   output logic [vit_pkg::ST_W-1:0]             bp_rdata,
   input  logic                                 pa_we,
   input  logic [$clog2(MAX_LEN)-1:0]           pa_waddr,
   input  logic [vit_pkg::ST_W-1:0]             pa_wdata,
   input  logic [$clog2(MAX_LEN)-1:0]           pa_raddr,
   output logic [vit_pkg::ST_W-1:0]             pa_rdata
);
   import vit_pkg::*;

   logic signed [SCORE_W-1:0] score_mem [2*MAX_STATES];
   logic [ST_W-1:0]           bp_mem    [MAX_LEN*MAX_STATES];
   logic [ST_W-1:0]           path_mem  [MAX_LEN];

   always_ff @(posedge clock) begin
      if (sc_we) begin
         score_mem[sc_waddr] <= sc_wdata;
      end
      if (bp_we) begin
         bp_mem[bp_waddr] <= bp_wdata;
      end
      if (pa_we) begin
         path_mem[pa_waddr] <= pa_wdata;
      end
      sc_rdata <= score_mem[sc_raddr];
      bp_rdata <= bp_mem[bp_raddr];
      pa_rdata <= path_mem[pa_raddr];
   end

endmodule

// ===== hdl/hmm_viterbi_decoder.sv =====
// Top level of the log-domain Viterbi decoder: sequencer and add-compare-select datapath.
// Depends on vit_pkg, vit_tables and vit_trellis.
//
// Usage: an input word is taken when start is high and busy is low. Table loads
// (kinds 0 to 2) are written in that cycle and leave busy low. An observation word
// with a symbol in range and room in the sequence raises busy while one shared
// add-compare-select unit walks every pair of active states, one pair per cycle
// (on the first observation of a sequence, only the active states themselves). A final
// observation then scans the end scores, backtracks through a read and a write
// state per step, and sends one result word per time step on consecutive cycles,
// each marked by rsp_valid for one cycle; the receiver cannot stall. An empty
// sequence gives one word in the cycle after its request. The configuration channel
// is always ready and is to be written by the user only while busy is low; the block
// does not enforce this. Reset clears the sequence length, the status flags and the
// sequencer and sets the registers to eight states and sixteen symbols; tables are kept.
module hmm_viterbi_decoder #(
   parameter int MAX_LEN = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_kind,
   input  logic [2:0]                          req_row_index,
   input  logic [3:0]                          req_col_index,
   input  logic signed [15:0]                  req_log_value,
   input  logic [3:0]                          req_symbol,
   input  logic                                req_final_req,
   output logic                                rsp_valid,
   output logic [2:0]                          rsp_path_state,
   output logic signed [31:0]                  rsp_best_score,
   output logic                                rsp_last,
   output logic [1:0]                          rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_index,
   input  logic [4:0]                          csr_wdata
);
   import vit_pkg::*;

   localparam int T_W   = $clog2(MAX_LEN);
   localparam int LEN_W = $clog2(MAX_LEN + 1);

   ctrl_state_type state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [1:0] flags_ff, flags_in;
   logic [3:0] num_states_ff;
   logic [4:0] num_symbols_ff;
   logic [3:0] active_ff, active_in;
   logic cur_ff, cur_in;
   logic fin_ff, fin_in;
   logic [SYM_W-1:0] sym_ff, sym_in;
   logic [ST_W-1:0] i_ff, i_in, j_ff, j_in;
   logic d1_valid_ff, d1_valid_in, d2_valid_ff, d2_valid_in;
   logic sc_valid_ff, sc_valid_in, o_valid_ff, o_valid_in;
   logic [ST_W-1:0] d1_i_ff, d1_i_in, d1_j_ff, d1_j_in, d2_j_ff, d2_j_in;
   logic [ST_W-1:0] sc_j_ff, sc_j_in, arg_ff, arg_in, st_ff, st_in;
   logic signed [SCORE_W-1:0] best_ff, best_in, cand;
   logic signed [VAL_W-1:0] emis_ff, emis_in;
   logic [T_W-1:0] tstep_ff, tstep_in, k_ff, k_in;
   logic o_last_ff, o_last_in;

   logic accept;
   logic [3:0] nst;
   logic [4:0] nsym;
   logic [ST_W-1:0] a_last;
   tbl_load_type tbl_ld;
   tbl_read_type tbl_rd;
   logic signed [VAL_W-1:0] trans_rd, emis_rd, init_rd;
   logic sc_we, bp_we, pa_we;
   logic [ST_W:0] sc_waddr, sc_raddr;
   logic signed [SCORE_W-1:0] sc_wdata, sc_rd;
   logic [T_W+ST_W-1:0] bp_waddr, bp_raddr;
   logic [ST_W-1:0] bp_wdata, bp_rd, pa_wdata, pa_rd;
   logic [T_W-1:0] pa_waddr, pa_raddr;

   vit_tables u_tables (
      .clock       (clock),
      .load        (tbl_ld),
      .rd          (tbl_rd),
      .trans_rdata (trans_rd),
      .emis_rdata  (emis_rd),
      .init_rdata  (init_rd)
   );

   vit_trellis #(.MAX_LEN(MAX_LEN)) u_trellis (
      .clock    (clock),
      .sc_we    (sc_we),
      .sc_waddr (sc_waddr),
      .sc_wdata (sc_wdata),
      .sc_raddr (sc_raddr),
      .sc_rdata (sc_rd),
      .bp_we    (bp_we),
      .bp_waddr (bp_waddr),
      .bp_wdata (bp_wdata),
      .bp_raddr (bp_raddr),
      .bp_rdata (bp_rd),
      .pa_we    (pa_we),
      .pa_waddr (pa_waddr),
      .pa_wdata (pa_wdata),
      .pa_raddr (pa_raddr),
      .pa_rdata (pa_rd)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign a_last    = ST_W'(active_ff - 4'd1);
   assign cand      = sat_add(sc_rd, sext_val(trans_rd));

   always_comb begin
      if (num_states_ff == 4'd0) begin
         nst = 4'd1;
      end else if (num_states_ff > 4'(MAX_STATES)) begin
         nst = 4'(MAX_STATES);
      end else begin
         nst = num_states_ff;
      end
      if (num_symbols_ff == 5'd0) begin
         nsym = 5'd1;
      end else if (num_symbols_ff > 5'(MAX_SYMBOLS)) begin
         nsym = 5'(MAX_SYMBOLS);
      end else begin
         nsym = num_symbols_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      flags_in    = flags_ff;
      active_in   = active_ff;
      cur_in      = cur_ff;
      fin_in      = fin_ff;
      sym_in      = sym_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      d1_valid_in = 1'b0;
      d2_valid_in = 1'b0;
      sc_valid_in = 1'b0;
      o_valid_in  = 1'b0;
      d1_i_in     = d1_i_ff;
      d1_j_in     = d1_j_ff;
      d2_j_in     = d2_j_ff;
      sc_j_in     = sc_j_ff;
      arg_in      = arg_ff;
      st_in       = st_ff;
      best_in     = best_ff;
      emis_in     = emis_ff;
      tstep_in    = tstep_ff;
      k_in        = k_ff;
      o_last_in   = o_last_ff;

      tbl_ld.en_trans = accept && (req_kind == KIND_TRANS) && !req_col_index[SYM_W-1];
      tbl_ld.en_emis  = accept && (req_kind == KIND_EMIS);
      tbl_ld.en_init  = accept && (req_kind == KIND_INIT);
      tbl_ld.row      = req_row_index;
      tbl_ld.col      = req_col_index;
      tbl_ld.value    = req_log_value;
      tbl_rd.trans_addr = {i_ff, j_ff};
      tbl_rd.emis_addr  = {j_ff, sym_ff};
      tbl_rd.init_addr  = j_ff;

      sc_we    = 1'b0;
      sc_waddr = {cur_ff, d1_j_ff};
      sc_wdata = best_ff;
      sc_raddr = {cur_ff, i_ff};
      bp_we    = 1'b0;
      bp_waddr = {len_ff[T_W-1:0], d2_j_ff};
      bp_wdata = arg_ff;
      bp_raddr = {tstep_ff, st_ff};
      pa_we    = 1'b0;
      pa_waddr = tstep_ff;
      pa_wdata = arg_ff;
      pa_raddr = k_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_kind == KIND_OBS)) begin
               fin_in = req_final_req;
               sym_in = req_symbol;
               j_in   = '0;
               i_in   = '0;
               if ({1'b0, req_symbol} >= nsym) begin
                  flags_in[1] = 1'b1;
               end else if (len_ff >= LEN_W'(MAX_LEN)) begin
                  flags_in[0] = 1'b1;
               end
               if (({1'b0, req_symbol} < nsym) && (len_ff < LEN_W'(MAX_LEN))) begin
                  if (len_ff == '0) begin
                     active_in = nst;
                  end
                  state_in = ST_OBS_RUN;
               end else if (req_final_req) begin
                  state_in = (len_ff == '0) ? ST_EMPTY : ST_BEST_RUN;
               end
            end
         end
         ST_OBS_RUN: begin
            d1_valid_in = 1'b1;
            d1_i_in     = i_ff;
            d1_j_in     = j_ff;
            if (len_ff == '0) begin
               if (j_ff == a_last) begin
                  state_in = ST_OBS_DRAIN;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else if (i_ff == a_last) begin
               i_in = '0;
               if (j_ff == a_last) begin
                  state_in = ST_OBS_DRAIN;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_OBS_DRAIN: begin
            if (!d1_valid_ff && !d2_valid_ff) begin
               len_in = len_ff + 1'b1;
               if (len_ff != '0) begin
                  cur_in = !cur_ff;
               end
               j_in     = '0;
               state_in = fin_ff ? ST_BEST_RUN : ST_IDLE;
            end
         end
         ST_BEST_RUN: begin
            sc_raddr    = {cur_ff, j_ff};
            sc_valid_in = 1'b1;
            sc_j_in     = j_ff;
            if (j_ff == a_last) begin
               state_in = ST_BEST_DRAIN;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_BEST_DRAIN: begin
            if (!sc_valid_ff) begin
               pa_we    = 1'b1;
               pa_waddr = T_W'(len_ff - 1'b1);
               pa_wdata = arg_ff;
               st_in    = arg_ff;
               tstep_in = T_W'(len_ff - 1'b1);
               k_in     = '0;
               state_in = (len_ff == LEN_W'(1)) ? ST_OUT_RUN : ST_TRACE_RD;
            end
         end
         ST_TRACE_RD: begin
            state_in = ST_TRACE_WR;
         end
         ST_TRACE_WR: begin
            pa_we    = 1'b1;
            pa_waddr = tstep_ff - 1'b1;
            pa_wdata = bp_rd;
            st_in    = bp_rd;
            tstep_in = tstep_ff - 1'b1;
            state_in = (tstep_ff == T_W'(1)) ? ST_OUT_RUN : ST_TRACE_RD;
         end
         ST_OUT_RUN: begin
            o_valid_in = 1'b1;
            o_last_in  = ({1'b0, k_ff} == LEN_W'(len_ff - 1'b1));
            if (o_last_in) begin
               state_in = ST_OUT_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_OUT_DRAIN: begin
            len_in   = '0;
            flags_in = '0;
            state_in = ST_IDLE;
         end
         ST_EMPTY: begin
            len_in   = '0;
            flags_in = '0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (d1_valid_ff) begin
         if (len_ff == '0) begin
            sc_we    = 1'b1;
            sc_waddr = {cur_ff, d1_j_ff};
            sc_wdata = sat_add(sext_val(init_rd), sext_val(emis_rd));
            bp_we    = 1'b1;
            bp_waddr = {T_W'(0), d1_j_ff};
            bp_wdata = d1_j_ff;
         end else begin
            if ((d1_i_ff == '0) || (cand > best_ff)) begin
               best_in = cand;
               arg_in  = d1_i_ff;
            end
            if (d1_i_ff == '0) begin
               emis_in = emis_rd;
            end
            if (d1_i_ff == a_last) begin
               d2_valid_in = 1'b1;
               d2_j_in     = d1_j_ff;
            end
         end
      end

      if (d2_valid_ff) begin
         sc_we    = 1'b1;
         sc_waddr = {!cur_ff, d2_j_ff};
         sc_wdata = sat_add(best_ff, sext_val(emis_ff));
         bp_we    = 1'b1;
         bp_waddr = {len_ff[T_W-1:0], d2_j_ff};
         bp_wdata = arg_ff;
      end

      if (sc_valid_ff) begin
         if ((sc_j_ff == '0) || (sc_rd > best_ff)) begin
            best_in = sc_rd;
            arg_in  = sc_j_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         len_ff         <= '0;
         flags_ff       <= '0;
         num_states_ff  <= 4'(MAX_STATES);
         num_symbols_ff <= 5'(MAX_SYMBOLS);
         active_ff      <= 4'(MAX_STATES);
         cur_ff         <= 1'b0;
         d1_valid_ff    <= 1'b0;
         d2_valid_ff    <= 1'b0;
         sc_valid_ff    <= 1'b0;
         o_valid_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         len_ff      <= len_in;
         flags_ff    <= flags_in;
         active_ff   <= active_in;
         cur_ff      <= cur_in;
         d1_valid_ff <= d1_valid_in;
         d2_valid_ff <= d2_valid_in;
         sc_valid_ff <= sc_valid_in;
         o_valid_ff  <= o_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_NUM_STATES) begin
               num_states_ff <= csr_wdata[3:0];
            end else begin
               num_symbols_ff <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      fin_ff    <= fin_in;
      sym_ff    <= sym_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      d1_i_ff   <= d1_i_in;
      d1_j_ff   <= d1_j_in;
      d2_j_ff   <= d2_j_in;
      sc_j_ff   <= sc_j_in;
      arg_ff    <= arg_in;
      st_ff     <= st_in;
      best_ff   <= best_in;
      emis_ff   <= emis_in;
      tstep_ff  <= tstep_in;
      k_ff      <= k_in;
      o_last_ff <= o_last_in;
   end

   assign rsp_valid      = o_valid_ff || (state_ff == ST_EMPTY);
   assign rsp_path_state = (state_ff == ST_EMPTY) ? '0 : pa_rd;
   assign rsp_best_score = (state_ff == ST_EMPTY) ? SCORE_MIN : best_ff;
   assign rsp_last       = (state_ff == ST_EMPTY) ? 1'b1 : o_last_ff;
   assign rsp_status     = flags_ff;

endmodule
